@@ rtl/wsd_pkg.sv @@
// shared types and constants for the websocket frame deframer
package wsd_pkg;

    // parser phase
    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_EXTLEN  = 3'd2,
        PH_MASK    = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    // kind of a result beat
    typedef enum logic [1:0] {
        KIND_HEADER    = 2'd0,
        KIND_PAYLOAD   = 2'd1,
        KIND_LEN_ERROR = 2'd2
    } t_kind;

    // length codes of the 7-bit length field
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // largest payload of a control frame
    localparam logic [63:0] CTRL_MAX_LEN = 64'd125;

    // remaining extended length and mask bytes, minus one
    localparam logic [2:0] CNT_EXT16 = 3'd1;
    localparam logic [2:0] CNT_EXT64 = 3'd7;
    localparam logic [2:0] CNT_MASK  = 3'd3;

    // output tdata width, 81 field bits padded to whole bytes
    localparam int unsigned OUT_DATA_W = 88;

    // one result beat
    typedef struct packed {
        t_kind       kind;
        logic        fin;
        logic [2:0]  rsv_bits;
        logic [3:0]  opcode;
        logic        masked;
        logic [63:0] payload_length;
        logic [7:0]  payload_byte;
        logic        last;
    } t_result;

endpackage

@@ rtl/wsd_parser.sv @@
// frame header parser and payload unmasking, one byte per cycle while i_beat is high
module wsd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_beat,
    input  logic [7:0]       i_data_byte,
    output logic             o_res_valid,
    output wsd_pkg::t_result o_res
);

    wsd_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_first_byte, n_first_byte;
    logic [63:0] r_length, n_length;
    logic [31:0] r_mask_key, n_mask_key;
    logic [63:0] r_remaining, n_remaining;
    logic [1:0]  r_mask_index, n_mask_index;
    logic [8:0]  r_flags, n_flags;

    logic        len_done;
    logic        hdr_done;
    logic        res_valid;
    wsd_pkg::t_kind res_kind;
    logic [7:0]  res_byte;
    logic        res_last;
    logic [7:0]  key_byte;
    logic [63:0] rem_dec;

    // mask key byte for the current payload position, first key byte on top
    always_comb begin
        unique case (r_mask_index)
            2'd0:    key_byte = r_mask_key[31:24];
            2'd1:    key_byte = r_mask_key[23:16];
            2'd2:    key_byte = r_mask_key[15:8];
            default: key_byte = r_mask_key[7:0];
        endcase
    end

    assign rem_dec = r_remaining - 64'd1;

    // next state and result
    always_comb begin
        n_phase      = r_phase;
        n_byte_count = r_byte_count;
        n_first_byte = r_first_byte;
        n_length     = r_length;
        n_mask_key   = r_mask_key;
        n_remaining  = r_remaining;
        n_mask_index = r_mask_index;
        n_flags      = r_flags;
        len_done     = 1'b0;
        hdr_done     = 1'b0;
        res_valid    = 1'b0;
        res_kind     = wsd_pkg::KIND_HEADER;
        res_byte     = 8'd0;
        res_last     = 1'b0;

        unique case (r_phase)
            wsd_pkg::PH_HDR1: begin
                n_flags = {r_first_byte[7], r_first_byte[6:4], r_first_byte[3:0],
                           i_data_byte[7]};
                if (i_data_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
                    n_length     = 64'd0;
                    n_byte_count = wsd_pkg::CNT_EXT16;
                    n_phase      = wsd_pkg::PH_EXTLEN;
                end else if (i_data_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
                    n_length     = 64'd0;
                    n_byte_count = wsd_pkg::CNT_EXT64;
                    n_phase      = wsd_pkg::PH_EXTLEN;
                end else begin
                    n_length = {57'd0, i_data_byte[6:0]};
                    len_done = 1'b1;
                end
            end
            wsd_pkg::PH_EXTLEN: begin
                n_length = {r_length[55:0], i_data_byte};
                if (r_byte_count == 3'd0) begin
                    len_done = 1'b1;
                end else begin
                    n_byte_count = r_byte_count - 3'd1;
                end
            end
            wsd_pkg::PH_MASK: begin
                n_mask_key = {r_mask_key[23:0], i_data_byte};
                if (r_byte_count == 3'd0) begin
                    hdr_done = 1'b1;
                end else begin
                    n_byte_count = r_byte_count - 3'd1;
                end
            end
            wsd_pkg::PH_PAYLOAD: begin
                res_valid    = 1'b1;
                res_kind     = wsd_pkg::KIND_PAYLOAD;
                res_byte     = r_flags[0] ? (i_data_byte ^ key_byte) : i_data_byte;
                n_mask_index = r_mask_index + 2'd1;
                n_remaining  = rem_dec;
                if (rem_dec == 64'd0) begin
                    res_last = 1'b1;
                    n_phase  = wsd_pkg::PH_HDR0;
                end
            end
            default: begin
                n_first_byte = i_data_byte;
                n_phase      = wsd_pkg::PH_HDR1;
            end
        endcase

        // length known: read the mask key next, or finish the header
        if (len_done) begin
            if (n_flags[0]) begin
                n_mask_key   = 32'd0;
                n_byte_count = wsd_pkg::CNT_MASK;
                n_phase      = wsd_pkg::PH_MASK;
            end else begin
                hdr_done = 1'b1;
            end
        end

        // header complete: error, empty frame or start of payload
        if (hdr_done) begin
            res_valid = 1'b1;
            if (n_flags[4] && (n_length > wsd_pkg::CTRL_MAX_LEN)) begin
                res_kind = wsd_pkg::KIND_LEN_ERROR;
                n_phase  = wsd_pkg::PH_HDR0;
            end else if (n_length == 64'd0) begin
                res_last = 1'b1;
                n_phase  = wsd_pkg::PH_HDR0;
            end else begin
                n_remaining  = n_length;
                n_mask_index = 2'd0;
                n_phase      = wsd_pkg::PH_PAYLOAD;
            end
        end
    end

    // parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= wsd_pkg::PH_HDR0;
            r_byte_count <= 3'd0;
            r_first_byte <= 8'd0;
            r_length     <= 64'd0;
            r_mask_key   <= 32'd0;
            r_remaining  <= 64'd0;
            r_mask_index <= 2'd0;
            r_flags      <= 9'd0;
        end else if (i_beat) begin
            r_phase      <= n_phase;
            r_byte_count <= n_byte_count;
            r_first_byte <= n_first_byte;
            r_length     <= n_length;
            r_mask_key   <= n_mask_key;
            r_remaining  <= n_remaining;
            r_mask_index <= n_mask_index;
            r_flags      <= n_flags;
        end
    end

    // result handed to the output stage in the cycle of the beat
    assign o_res_valid          = i_beat & res_valid;
    assign o_res.kind           = res_kind;
    assign o_res.fin            = n_flags[8];
    assign o_res.rsv_bits       = n_flags[7:5];
    assign o_res.opcode         = n_flags[4:1];
    assign o_res.masked         = n_flags[0];
    assign o_res.payload_length = n_length;
    assign o_res.payload_byte   = res_byte;
    assign o_res.last           = res_last;

endmodule

@@ rtl/wsd_out_buf.sv @@
// two-entry result register with skid, decouples input ready from output ready
module wsd_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  wsd_pkg::t_result i_wr_res,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_ready,
    output wsd_pkg::t_result o_res
);

    wsd_pkg::t_result r_buf [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) & i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_res   = r_buf[r_rd_ptr];

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = i_wr ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + {1'b0, i_wr} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_buf[r_wr_ptr] <= i_wr_res;
        end
    end

endmodule

@@ rtl/websocket_frame_deframer.sv @@
// websocket frame deframer top level: byte stream in, header and payload results out
// Takes one raw connection byte per beat and can accept a byte in every cycle unless
// the output buffer is full; each byte is fully handled in the cycle it is accepted,
// and its result (if any) is written into the output buffer. Header bytes, extended
// length bytes and mask bytes give no result except the byte that completes the header,
// which gives a header beat (tlast set for an empty payload) or, for a control frame
// longer than 125 bytes, a length error beat after which the next byte starts a new
// header. Every payload byte gives one beat, unmasked, with tlast on the final one. A
// two-entry output buffer lets the slave side keep taking bytes while one result waits;
// tready drops only when both entries are held.
module websocket_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // fin, rsv_bits[3:1], opcode[7:4], masked, payload_length[72:9],
    // payload_byte[80:73], zero pad
    output logic [wsd_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // out_kind
    output logic        o_m_axis_tlast    // last
);

    logic             beat;
    logic             res_valid;
    wsd_pkg::t_result res;
    logic             buf_full;
    wsd_pkg::t_result out_res;

    assign o_s_axis_tready = ~buf_full;
    assign beat            = i_s_axis_tvalid & ~buf_full;

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_data_byte (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (res_valid),
        .i_wr_res (res),
        .o_full   (buf_full),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_res    (out_res)
    );

    // pack the result beat
    assign o_m_axis_tdata = {7'd0, out_res.payload_byte, out_res.payload_length,
                             out_res.masked, out_res.opcode, out_res.rsv_bits,
                             out_res.fin};
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.last;

endmodule
